// ===== rtl/dro_pkg.sv =====
`default_nettype none
package dro_pkg;

   // Register indexes of the configuration port.
   localparam logic [0:0] REG_LINEAR_LIMIT  = 1'b0;
   localparam logic [0:0] REG_ANGULAR_LIMIT = 1'b1;

   localparam logic [15:0] LINEAR_LIMIT_RESET  = 16'd7;
   localparam logic [30:0] ANGULAR_LIMIT_RESET = 31'd683565;

   // Gain that turns rad into 2^-32 turn, scaled by 2^2.
   localparam logic [31:0] TURN_GAIN    = 32'd2734261102;
   localparam logic [31:0] CORDIC_START = 32'd652032874;

   // Arctangent table of the CORDIC, 2^-32 turn.
   function automatic logic [31:0] atan_entry(input logic [4:0] i);
      logic [31:0] r;
      begin
         case (i)
            5'd0: r = 32'h20000000; 5'd1: r = 32'h12E4051E; 5'd2: r = 32'h09FB385B;
            5'd3: r = 32'h051111D4; 5'd4: r = 32'h028B0D43; 5'd5: r = 32'h0145D7E1;
            5'd6: r = 32'h00A2F61E; 5'd7: r = 32'h00517C55; 5'd8: r = 32'h0028BE53;
            5'd9: r = 32'h00145F2F; 5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3; 5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D; 5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518; 5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146; 5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014; 5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005; 5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
            5'd30: r = 32'h00000001;
            default: r = 32'h00000000;
         endcase
         atan_entry = r;
      end
   endfunction

   // Control between the sequencer and the CORDIC unit.
   typedef struct packed {
      logic        start;
      logic [31:0] angle;
   } cordic_cmd_type;

   typedef struct packed {
      logic               done;
      logic signed [33:0] cos_q30;
      logic signed [33:0] sin_q30;
   } cordic_rsp_type;

endpackage
`default_nettype wire

// ===== rtl/dro_cordic.sv =====
`default_nettype none
module dro_cordic #(
   parameter int STEPS = 16
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire dro_pkg::cordic_cmd_type cmd,
   output dro_pkg::cordic_rsp_type rsp
);
   import dro_pkg::*;

   localparam int CW = $clog2(STEPS + 1);

   logic               busy_ff, busy_in;
   logic [CW-1:0]      step_ff, step_in;
   logic [1:0]         quad_ff, quad_in;
   logic signed [33:0] x_ff, x_in, y_ff, y_in;
   logic signed [33:0] z_ff, z_in;
   logic               done_ff, done_in;
   logic [1:0]         q;
   logic signed [33:0] sx, sy;
   logic [31:0]        at;
   logic [31:0]        red;
   logic [4:0]         idx;

   // One rotation per cycle; the shift is arithmetic, which floors.
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      quad_in = quad_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      done_in = 1'b0;
      q   = 2'((cmd.angle + 32'h20000000) >> 30);
      red = cmd.angle - {q, 30'd0};
      idx = 5'(step_ff);
      sx  = y_ff >>> idx;
      sy  = x_ff >>> idx;
      at  = atan_entry(idx);
      if (cmd.start) begin
         busy_in = 1'b1;
         step_in = '0;
         quad_in = q;
         x_in    = {2'b00, CORDIC_START};
         y_in    = '0;
         z_in    = {{2{red[31]}}, red};
      end else if (busy_ff) begin
         if (step_ff == CW'(STEPS)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            if (!z_ff[33]) begin
               x_in = x_ff - sx; y_in = y_ff + sy; z_in = z_ff - {2'b00, at};
            end else begin
               x_in = x_ff + sx; y_in = y_ff - sy; z_in = z_ff + {2'b00, at};
            end
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quad_ff <= quad_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   // Quadrant fold-back.
   always_comb begin
      rsp.done = done_ff;
      case (quad_ff)
         2'd0: begin rsp.cos_q30 = x_ff;  rsp.sin_q30 = y_ff;  end
         2'd1: begin rsp.cos_q30 = -y_ff; rsp.sin_q30 = x_ff;  end
         2'd2: begin rsp.cos_q30 = -x_ff; rsp.sin_q30 = -y_ff; end
         default: begin rsp.cos_q30 = y_ff; rsp.sin_q30 = -x_ff; end
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/dro_serial_mul.sv =====
`default_nettype none
module dro_serial_mul (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   input  wire signed [33:0] mcand,
   input  wire        [33:0] mplier,
   input  wire               mplier_neg,
   output logic              done,
   output logic signed [67:0] product
);
   import dro_pkg::*;

   // Shift-and-add multiplier, one multiplier bit a cycle. The magnitude of the
   // multiplier is shifted out; the sign is applied at the end.
   logic [33:0]        mp_ff, mp_in;
   logic signed [67:0] acc_ff, acc_in;
   logic signed [67:0] mc_ff, mc_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic               busy_ff, busy_in, neg_ff, neg_in, done_ff, done_in;

   always_comb begin
      mp_in = mp_ff; acc_in = acc_ff; mc_in = mc_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; neg_in = neg_ff; done_in = 1'b0;
      if (start) begin
         mp_in   = mplier;
         acc_in  = '0;
         mc_in   = 68'(mcand);
         cnt_in  = '0;
         busy_in = 1'b1;
         neg_in  = mplier_neg;
      end else if (busy_ff) begin
         if (mp_ff[0]) acc_in = acc_ff + mc_ff;
         mp_in  = mp_ff >> 1;
         mc_in  = mc_ff <<< 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == 6'd33) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mp_ff  <= mp_in;
      acc_ff <= acc_in;
      mc_ff  <= mc_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

   assign done    = done_ff;
   assign product = neg_ff ? -acc_ff : acc_ff;

endmodule
`default_nettype wire

// ===== rtl/dead_reckoning_odometry.sv =====
`default_nettype none
// Channel   Direction  Contents
// req_      in         tdata: linear_speed, turn_rate, elapsed; tuser: clear_pose
// rsp_      out        tdata: pos_x, pos_y, heading_out, quat_z, quat_w,
//                      world_vel_x, world_vel_y, turn_rate_out; tuser: moving
// csr_      in         write enable, index, 31-bit data
//
// A motion item's result comes from three CORDIC runs and five products through the
// bit-serial multiplier, one multiplier bit a cycle. A clear item's result is ready
// in the cycle after it is accepted. Reset is synchronous; it clears the pose and the
// result and loads the limit registers with their reset values. The next item is
// accepted only once the previous result has been taken on rsp_.
module dead_reckoning_odometry #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [47:0] req_tdata,  // linear_speed, turn_rate, elapsed
   input  wire         req_tuser,  // clear_pose
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [159:0] rsp_tdata, // pos_x, pos_y, heading_out, quat_z, quat_w,
                                   // world_vel_x, world_vel_y, turn_rate_out
   output logic        rsp_tuser,  // moving
   input  wire         csr_we,
   input  wire  [0:0]  csr_index,
   input  wire  [30:0] csr_wdata
);
   import dro_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0,  S_CS1 = 4'd1,  S_MDX = 4'd2, S_MDX2 = 4'd3,
                          S_MDY = 4'd4,  S_MDY2 = 4'd5, S_MTH = 4'd6, S_MTH2 = 4'd7,
                          S_CS2 = 4'd8,  S_MVX = 4'd9,  S_MVY = 4'd10, S_CS3 = 4'd11,
                          S_OUT = 4'd12;

   logic [3:0]  st_ff, st_in;
   logic [15:0] lin_lim_ff;
   logic [30:0] ang_lim_ff;
   logic signed [31:0] px_ff, py_ff;
   logic [31:0] hd_ff;
   logic signed [15:0] spd_ff, rate_ff;
   logic [15:0] dt_ff;
   logic signed [33:0] c_ff, s_ff;
   logic signed [33:0] dx_ff, dy_ff, dth_ff;
   logic signed [15:0] vx_ff, vy_ff;
   logic        out_v_ff;
   logic [159:0] out_d_ff;
   logic        out_u_ff;

   cordic_cmd_type ccmd;
   cordic_rsp_type crsp;
   logic        m_start, m_done, m_neg;
   logic signed [33:0] m_a;
   logic [33:0] m_b;
   logic signed [67:0] m_p;

   dro_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .reset(reset), .cmd(ccmd), .rsp(crsp));

   dro_serial_mul u_mul (
      .clock(clock), .reset(reset), .start(m_start), .mcand(m_a),
      .mplier(m_b), .mplier_neg(m_neg), .done(m_done), .product(m_p));

   // Round to nearest, ties away from zero, of v >> k.
   function automatic logic signed [67:0] rnd(input logic signed [67:0] v,
                                              input logic [5:0] k);
      logic [67:0] m, r;
      begin
         m = v[67] ? 68'(-v) : 68'(v);
         r = (m + (68'd1 << (k - 6'd1))) >> k;
         rnd = v[67] ? -$signed(r) : $signed(r);
      end
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [67:0] v);
      begin
         if (v > 68'sd32767) sat16 = 16'sh7fff;
         else if (v < -68'sd32768) sat16 = 16'sh8000;
         else sat16 = v[15:0];
      end
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      begin
         if (v > 34'sh07fffffff) sat32 = 32'sh7fffffff;
         else if (v < -34'sh080000000) sat32 = 32'sh80000000;
         else sat32 = v[31:0];
      end
   endfunction

   function automatic logic [33:0] mag34(input logic signed [33:0] v);
      mag34 = v[33] ? 34'(-v) : 34'(v);
   endfunction

   logic signed [33:0] sp_dt;
   logic signed [33:0] rdx, rdy, rdth, nx, ny;
   logic [31:0] nh;
   logic        acc;

   always_comb begin
      acc = req_tvalid && req_tready;
      sp_dt = 34'(spd_ff) * 34'($signed({1'b0, dt_ff}));
      rdx  = 34'(rnd(m_p, 6'd42));
      rdy  = rdx;
      rdth = 34'(rnd(m_p, 6'd30));
      nx = 34'(px_ff) + dx_ff;
      ny = 34'(py_ff) + dy_ff;
      nh = hd_ff + rdth[31:0];
   end

   // Sequencer: start signals and state.
   always_comb begin
      st_in = st_ff;
      ccmd.start = 1'b0;
      ccmd.angle = hd_ff;
      m_start = 1'b0;
      m_a = c_ff;
      m_b = mag34(sp_dt);
      m_neg = sp_dt[33];
      unique case (st_ff)
         S_IDLE: if (acc && !req_tuser) begin
            st_in = S_CS1; ccmd.start = 1'b1;
         end
         S_CS1: if (crsp.done) begin st_in = S_MDX; m_start = 1'b1; m_a = crsp.cos_q30; end
         S_MDX: if (m_done) begin st_in = S_MDY; m_start = 1'b1; m_a = s_ff; end
         S_MDY: if (m_done) begin
            st_in = S_MTH; m_start = 1'b1; m_a = {2'b00, TURN_GAIN};
            m_b = mag34(34'(rate_ff) * 34'($signed({1'b0, dt_ff})));
            m_neg = rate_ff[15] && (dt_ff != 16'd0);
         end
         S_MTH: if (m_done) begin
            st_in = S_CS2; ccmd.start = 1'b1; ccmd.angle = nh;
         end
         S_CS2: if (crsp.done) begin
            st_in = S_MVX; m_start = 1'b1; m_a = crsp.cos_q30;
            m_b = mag34(34'(spd_ff)); m_neg = spd_ff[15];
         end
         S_MVX: if (m_done) begin
            st_in = S_MVY; m_start = 1'b1; m_a = s_ff;
            m_b = mag34(34'(spd_ff)); m_neg = spd_ff[15];
         end
         S_MVY: if (m_done) begin
            st_in = S_CS3; ccmd.start = 1'b1; ccmd.angle = {1'b0, hd_ff[31:1]};
         end
         S_CS3: if (crsp.done) st_in = S_OUT;
         S_OUT: st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   logic moving;
   always_comb begin
      moving = (mag34(dx_ff) >= 34'(lin_lim_ff)) || (mag34(dy_ff) >= 34'(lin_lim_ff)) ||
               (mag34(dth_ff) >= 34'(ang_lim_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         lin_lim_ff <= LINEAR_LIMIT_RESET;
         ang_lim_ff <= ANGULAR_LIMIT_RESET;
         px_ff <= '0; py_ff <= '0; hd_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_LINEAR_LIMIT:  lin_lim_ff <= csr_wdata[15:0];
               REG_ANGULAR_LIMIT: ang_lim_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) out_v_ff <= 1'b0;
         if (acc) begin
            spd_ff <= req_tdata[15:0];
            rate_ff <= req_tdata[31:16];
            dt_ff <= req_tdata[47:32];
            if (req_tuser) begin
               px_ff <= '0; py_ff <= '0; hd_ff <= '0;
               out_v_ff <= 1'b1;
               out_u_ff <= 1'b0;
               out_d_ff <= {16'd0, 16'd0, 16'd0, 16'd32767, 16'd0, 16'd0, 32'd0, 32'd0};
            end
         end
         if (st_ff == S_CS1 && crsp.done) s_ff <= crsp.sin_q30;
         if (st_ff == S_MDX && m_done) dx_ff <= rdx;
         if (st_ff == S_MDY && m_done) dy_ff <= rdy;
         if (st_ff == S_MTH && m_done) begin
            dth_ff <= rdth;
            px_ff <= sat32(nx);
            py_ff <= sat32(ny);
            hd_ff <= nh;
         end
         if (st_ff == S_CS2 && crsp.done) s_ff <= crsp.sin_q30;
         if (st_ff == S_MVX && m_done) vx_ff <= sat16(rnd(m_p, 6'd30));
         if (st_ff == S_MVY && m_done) vy_ff <= sat16(rnd(m_p, 6'd30));
         if (st_ff == S_CS3 && crsp.done) begin
            c_ff <= crsp.cos_q30;
            s_ff <= crsp.sin_q30;
         end
         if (st_ff == S_OUT) begin
            out_v_ff <= 1'b1;
            out_u_ff <= moving;
            out_d_ff <= {rate_ff, vy_ff, vx_ff,
                         sat16(rnd(68'(c_ff), 6'd15)), sat16(rnd(68'(s_ff), 6'd15)),
                         hd_ff[31:16], py_ff, px_ff};
         end
      end
   end

   assign req_tready = (st_ff == S_IDLE) && !out_v_ff;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;
   assign rsp_tuser  = out_u_ff;

endmodule
`default_nettype wire

// ===== rtl/dro_checker.sv =====
`default_nettype none
module dro_checker (
   input wire         clock,
   input wire         reset,
   input wire         req_tvalid,
   input wire         req_tready,
   input wire         rsp_tvalid,
   input wire         rsp_tready,
   input wire [159:0] rsp_tdata,
   input wire         rsp_tuser
);
   import dro_pkg::*;

   // A waiting result holds still.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // No item is taken while a result waits.
   a_one: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("item accepted with a result pending");

   // An accepted item closes the input for at least the next cycle.
   a_take: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input still open after an item was taken");

   // Reset leaves no result offered.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered after reset");

endmodule

bind dead_reckoning_odometry dro_checker u_dro_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser));
`default_nettype wire
